// ===== rtl/core/b2b_pkg.sv =====
// ----------------------------------------------------------------------------
// b2b_pkg: shared types and constants of the BLAKE2b stream hasher.
// Holds the channel payload structs, the sequencer states, the initial
// vector and the sigma schedule.
// ----------------------------------------------------------------------------
package b2b_pkg;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_INIT,
    ST_MIX,
    ST_FOLD,
    ST_EMIT
  } state_t;

  localparam logic [31:0] PARAM_WORD = 32'h0101_0000;
  localparam logic [6:0]  DIGEST_LENGTH_RESET = 7'd64;
  localparam int          NUM_ROUNDS = 12;

  localparam logic [63:0] IV [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
    64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  // Sigma schedule, one message word index per nibble, entry 0 in the low bits.
  localparam logic [63:0] SIGMA [10] = '{
    64'hFEDCBA9876543210, 64'h357B20C16DF984AE,
    64'h491763EADF250C8B, 64'h8F04A562EBCD1397,
    64'hD386CB1EFA427509, 64'h91EF57D438B0A6C2,
    64'hB8293670A4DEF15C, 64'hA2684F05931CE7BD,
    64'h5A417D2C803B9EF6, 64'h0DC3E9BF5167482A
  };

  // Work vector positions for each of the eight G steps of a round.
  localparam logic [15:0] MIX_POS [8] = '{
    16'hC840, 16'hD951, 16'hEA62, 16'hFB73,
    16'hFA50, 16'hCB61, 16'hD872, 16'hE943
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ===== rtl/core/blake2b_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// blake2b_stream_hasher_top: unkeyed BLAKE2b hasher over a word stream.
// ----------------------------------------------------------------------------
// Usage: message words enter on in_valid/in_ready as little-endian 64-bit
// words with a byte count and a last mark. The configuration channel
// (cfg_valid/cfg_ready/cfg_data) sets the digest length and must be written
// only while the block is idle; the block itself does not enforce this.
// A word that needs no compression is taken and the block is ready again
// in the next cycle. A word that follows a full held block, or a last word,
// starts a compression: half a G step per cycle on a shared mixing unit for
// 12 rounds, after a state that loads the work vector and before one that
// folds it into the chain. A last word adds a padding state before its
// final compression; one with data that follows a full held block runs two
// compressions. The eight digest words leave on out_valid/out_ready, word 0
// first, one per cycle at best; out_data holds while the receiver stalls,
// and no input request is taken until the last digest word is delivered.
// No word is taken while a 128-byte block compresses.
// Reset returns the sequencer to idle, clears the byte count and restores
// the digest length to 64.
// ----------------------------------------------------------------------------
module blake2b_stream_hasher_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  b2b_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output b2b_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data
);
  import b2b_pkg::*;

  state_t state, state_next;
  logic [6:0]  digest_length;
  logic [63:0] chain [8];
  logic [63:0] mblk [16];
  logic [63:0] v [16];
  logic [63:0] byte_counter;
  logic [3:0]  word_position;
  logic        block_pending;
  logic        in_message;
  logic        final_pending;
  logic        final_flag;
  logic [3:0]  round_index;
  logic [2:0]  step;
  logic        half;
  logic [2:0]  emit_idx;

  // Deferred word held while the pending block compresses.
  logic [63:0] pend_word;
  logic [3:0]  pend_cnt;

  logic        in_fire;
  logic [3:0]  cnt;
  logic [63:0] word_masked;
  logic [63:0] mask;

  // Accept input only while idle; configuration is always taken.
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  // Effective byte count and masked word.
  always_comb begin
    cnt = (!in_data.is_last || in_data.valid_bytes > 4'd8) ? 4'd8 : in_data.valid_bytes;
    mask = (cnt == 4'd8) ? '1 : ((64'd1 << {cnt[2:0], 3'b000}) - 64'd1);
    word_masked = in_data.message_word & mask;
  end

  // Shared G unit: half a G step per cycle on four work vector entries.
  // The first half adds the even message word and rotates by 32 and 24,
  // the second adds the odd word and rotates by 16 and 63.
  logic [15:0] pos;
  logic [3:0]  pa, pb, pc, pd;
  logic [63:0] sig;
  logic [3:0]  round_mod;
  logic [63:0] mx, my, gx;
  logic [63:0] ga, gd, gc, gb;
  always_comb begin
    round_mod = (round_index >= 4'd10) ? round_index - 4'd10 : round_index;
    sig = SIGMA[round_mod];
    pos = MIX_POS[step];
    pa = pos[3:0];
    pb = pos[7:4];
    pc = pos[11:8];
    pd = pos[15:12];
    mx = mblk[sig[{step, 3'b000} +: 4]];
    my = mblk[sig[{step, 3'b100} +: 4]];
    gx = half ? my : mx;
    ga = v[pa] + v[pb] + gx;
    gd = half ? rotr(v[pd] ^ ga, 16) : rotr(v[pd] ^ ga, 32);
    gc = v[pc] + gd;
    gb = half ? rotr(v[pb] ^ gc, 63) : rotr(v[pb] ^ gc, 24);
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if ((cnt != 4'd0) && block_pending && in_message) state_next = ST_INIT;
          else if (in_data.is_last) state_next = ST_PAD;
        end
      end
      ST_PAD:  state_next = ST_INIT;
      ST_INIT: state_next = ST_MIX;
      ST_MIX: begin
        if (half && step == 3'd7 && round_index == 4'(NUM_ROUNDS - 1)) state_next = ST_FOLD;
      end
      ST_FOLD: state_next = final_flag ? ST_EMIT : (final_pending ? ST_PAD : ST_IDLE);
      ST_EMIT: begin
        if (out_ready && emit_idx == 3'd7) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      digest_length <= DIGEST_LENGTH_RESET;
      byte_counter <= '0;
      word_position <= '0;
      block_pending <= 1'b0;
      in_message <= 1'b0;
      final_pending <= 1'b0;
      final_flag <= 1'b0;
      round_index <= '0;
      step <= '0;
      half <= 1'b0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) digest_length <= cfg_data;
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            in_message <= 1'b1;
            if (cnt != 4'd0) begin
              if (block_pending && in_message) begin
                // Held block goes first; this word waits in a spare slot.
                block_pending <= 1'b0;
                final_pending <= in_data.is_last;
              end else begin
                word_position <= (in_message ? word_position : 4'd0) + 4'd1;
                block_pending <= in_message && (word_position == 4'd15);
                byte_counter <= (in_message ? byte_counter : 64'd0) + 64'(cnt);
              end
            end else if (!in_message) begin
              byte_counter <= '0;
              word_position <= '0;
              block_pending <= 1'b0;
            end
          end
        end
        ST_PAD: final_flag <= 1'b1;
        ST_INIT: begin
          step <= '0;
          half <= 1'b0;
          round_index <= '0;
        end
        ST_MIX: begin
          half <= !half;
          if (half) begin
            step <= step + 3'd1;
            if (step == 3'd7) round_index <= round_index + 4'd1;
          end
        end
        ST_FOLD: begin
          round_index <= '0;
          if (!final_flag && final_pending) final_pending <= 1'b0;
          if (!final_flag) begin
            // The deferred word now opens the new block.
            word_position <= 4'd1;
            byte_counter <= byte_counter + 64'(pend_cnt);
          end
          emit_idx <= '0;
        end
        ST_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              in_message <= 1'b0;
              final_flag <= 1'b0;
              block_pending <= 1'b0;
              word_position <= '0;
              byte_counter <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath: message block, work vector and chain words.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++)
        chain[i] <= (i == 0) ?
          (IV[0] ^ {32'd0, PARAM_WORD} ^ {57'd0, DIGEST_LENGTH_RESET}) : IV[i];
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (!in_message) begin
              for (int i = 0; i < 8; i++)
                chain[i] <= (i == 0) ?
                  (IV[0] ^ {32'd0, PARAM_WORD} ^ {57'd0, digest_length}) : IV[i];
            end
            if (cnt != 4'd0) begin
              if (block_pending && in_message) begin
                pend_word <= word_masked;
                pend_cnt <= cnt;
              end else begin
                mblk[in_message ? word_position : 4'd0] <= word_masked;
              end
            end
          end
        end
        ST_PAD: begin
          if (!block_pending)
            for (int k = 0; k < 16; k++)
              if (4'(k) >= word_position) mblk[k] <= '0;
        end
        ST_INIT: begin
          for (int i = 0; i < 8; i++) begin
            v[i] <= chain[i];
            if (i == 4) v[12] <= IV[4] ^ byte_counter;
            else if (i == 6) v[14] <= final_flag ? ~IV[6] : IV[6];
            else v[i + 8] <= IV[i];
          end
        end
        ST_MIX: begin
          v[pa] <= ga;
          v[pb] <= gb;
          v[pc] <= gc;
          v[pd] <= gd;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] ^ v[i] ^ v[i + 8];
          if (!final_flag) mblk[0] <= pend_word;
        end
        default: ;
      endcase
    end
  end

  // Output channel.
  assign out_valid = (state == ST_EMIT);
  assign out_data.digest_word = chain[emit_idx];
  assign out_data.word_index  = emit_idx;
  assign out_data.digest_end  = (emit_idx == 3'd7);

  // Checks.
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_end_on_seven: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.digest_end) |-> (emit_idx == 3'd7)) else $error("bad end");
  a_emit_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.digest_end) |=> (state == ST_IDLE))
    else $error("no idle after digest");

endmodule

// ===== tb/sv/tb_blake2b_stream_hasher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blake2b_stream_hasher_top: self-checking bench for the BLAKE2b hasher.
// Messages of random length and content are streamed in as 64-bit words, and
// each digest word is checked against a behavioral BLAKE2b model kept here.
// The digest length is changed between phases, and both sides idle at random.
// ----------------------------------------------------------------------------
module tb_blake2b_stream_hasher_top;
  import b2b_pkg::*;

  localparam int MAX_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;

  blake2b_stream_hasher_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Model state of the hasher.
  logic [6:0]  hash_len;
  logic [63:0] chain_h [8];
  logic [63:0] block_m [16];
  logic [63:0] mix_v [16];
  logic [63:0] total_bytes;
  int          fill_pos;
  bit          full_block_held;
  bit          msg_open;

  out_item_t digest_queue [$];
  int errors = 0;
  int messages_done = 0;
  int words_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Idling probabilities, in percent.
  const int send_gap_pct = 71;

  function automatic logic [63:0] rot64(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic int sigma_at(int r, int k);
    int tbl [10][16] = '{
      '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
      '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
      '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
      '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
      '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
      '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
      '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
      '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
      '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
      '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};
    return tbl[r][k];
  endfunction

  task automatic g_step(int a, int b, int c, int d, logic [63:0] x, logic [63:0] y);
    mix_v[a] = mix_v[a] + mix_v[b] + x;
    mix_v[d] = rot64(mix_v[d] ^ mix_v[a], 32);
    mix_v[c] = mix_v[c] + mix_v[d];
    mix_v[b] = rot64(mix_v[b] ^ mix_v[c], 24);
    mix_v[a] = mix_v[a] + mix_v[b] + y;
    mix_v[d] = rot64(mix_v[d] ^ mix_v[a], 16);
    mix_v[c] = mix_v[c] + mix_v[d];
    mix_v[b] = rot64(mix_v[b] ^ mix_v[c], 63);
  endtask

  task automatic compress_block(bit final_blk);
    int s;
    for (int i = 0; i < 8; i++) begin
      mix_v[i] = chain_h[i];
      mix_v[i + 8] = IV[i];
    end
    mix_v[12] ^= total_bytes;
    if (final_blk) mix_v[14] = ~mix_v[14];
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      s = r % 10;
      g_step(0, 4, 8, 12, block_m[sigma_at(s, 0)], block_m[sigma_at(s, 1)]);
      g_step(1, 5, 9, 13, block_m[sigma_at(s, 2)], block_m[sigma_at(s, 3)]);
      g_step(2, 6, 10, 14, block_m[sigma_at(s, 4)], block_m[sigma_at(s, 5)]);
      g_step(3, 7, 11, 15, block_m[sigma_at(s, 6)], block_m[sigma_at(s, 7)]);
      g_step(0, 5, 10, 15, block_m[sigma_at(s, 8)], block_m[sigma_at(s, 9)]);
      g_step(1, 6, 11, 12, block_m[sigma_at(s, 10)], block_m[sigma_at(s, 11)]);
      g_step(2, 7, 8, 13, block_m[sigma_at(s, 12)], block_m[sigma_at(s, 13)]);
      g_step(3, 4, 9, 14, block_m[sigma_at(s, 14)], block_m[sigma_at(s, 15)]);
    end
    for (int i = 0; i < 8; i++) chain_h[i] ^= mix_v[i] ^ mix_v[i + 8];
  endtask

  task automatic hasher_reset();
    hash_len = DIGEST_LENGTH_RESET;
    msg_open = 1'b0;
    total_bytes = '0;
    fill_pos = 0;
    full_block_held = 1'b0;
  endtask

  // Absorb one accepted word; a last word queues the eight digest words.
  task automatic absorb_word(in_item_t it);
    logic [63:0] w;
    int cnt;
    out_item_t o;
    w = it.message_word;
    cnt = it.valid_bytes;
    if (!msg_open) begin
      for (int i = 0; i < 8; i++) chain_h[i] = IV[i];
      chain_h[0] ^= {32'h0, PARAM_WORD} ^ {57'h0, hash_len};
      total_bytes = '0;
      fill_pos = 0;
      full_block_held = 1'b0;
      msg_open = 1'b1;
    end
    if (!it.is_last || cnt > 8) cnt = 8;
    if (cnt < 8) w &= (64'd1 << (8 * cnt)) - 64'd1;
    if (cnt > 0) begin
      if (full_block_held) begin
        compress_block(1'b0);
        full_block_held = 1'b0;
        fill_pos = 0;
      end
      block_m[fill_pos] = w;
      total_bytes += cnt;
      fill_pos = (fill_pos + 1) % 16;
      if (fill_pos == 0) full_block_held = 1'b1;
    end
    if (!it.is_last) return;
    if (!full_block_held)
      for (int k = fill_pos; k < 16; k++) block_m[k] = '0;
    compress_block(1'b1);
    for (int k = 0; k < 8; k++) begin
      o.digest_word = chain_h[k];
      o.word_index = k[2:0];
      o.digest_end = (k == 7);
      digest_queue.push_back(o);
    end
    msg_open = 1'b0;
    full_block_held = 1'b0;
    fill_pos = 0;
    total_bytes = '0;
  endtask

  // Receiver side: random stalls, checks each digest word on acceptance.
  always @(posedge clk) begin
    out_item_t exp_item;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest word, actual %h", $time, out_data);
        errors++;
      end else begin
        exp_item = digest_queue.pop_front();
        if (out_data !== exp_item) begin
          $display("%0t: digest mismatch, expected %h actual %h", $time, exp_item,
                   out_data);
          errors++;
        end
      end
    end
    if (cycle_count > MAX_CYCLES) begin
      $display("%0t: run timed out", $time);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Send one word and wait for its acceptance, with random gaps before it.
  // The request stays up after acceptance so the next word can follow at
  // once; a caller that pauses drops in_valid first.
  task automatic send_word(logic [63:0] w, logic [3:0] n, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= '{message_word: w, valid_bytes: n, is_last: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_word('{message_word: w, valid_bytes: n, is_last: last});
    words_sent++;
    if (last) messages_done++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (digest_queue.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic write_length(logic [6:0] len);
    cfg_data <= len;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hash_len = len;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random message: mostly short, a few spanning several blocks.
  task automatic send_message(int nwords);
    logic [63:0] w;
    int tail;
    for (int i = 0; i < nwords; i++) begin
      w = {$urandom, $urandom};
      send_word(w, 4'($urandom_range(15)), 1'b0);
    end
    w = {$urandom, $urandom};
    tail = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8);
    send_word(w, 4'(tail), 1'b1);
  endtask

  typedef struct {
    logic [63:0] w;
    logic [3:0] n;
    bit last;
  } stim_row_t;

  stim_row_t directed [] = '{
    '{64'h0, 4'd0, 1'b1},                    // empty message
    '{64'h0000000000636261, 4'd3, 1'b1},     // "abc"
    '{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1},
    '{64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b1},    // count above eight
    '{64'hFFFFFFFFFFFFFFFF, 4'd7, 1'b0},     // non-final word counts as eight
    '{64'h0123456789ABCDEF, 4'd1, 1'b1},
    '{64'h0, 4'd8, 1'b0},
    '{64'h5555555555555555, 4'd0, 1'b1}      // final word with no data
  };

  initial begin
    hasher_reset();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows; the "abc" digest is checked by value as well.
    foreach (directed[i]) begin
      send_word(directed[i].w, directed[i].n, directed[i].last);
      if (i == 1 && digest_queue.size() >= 8 &&
          digest_queue[digest_queue.size() - 8].digest_word !== 64'h0D4D1C983FA580BA) begin
        $display("%0t: model abc digest, expected %h actual %h", $time,
                 64'h0D4D1C983FA580BA, digest_queue[digest_queue.size() - 8].digest_word);
        errors++;
      end
    end
    // Sixteen words with a random tail count, then a full block plus one zero-count tail.
    send_message(15);
    for (int i = 0; i < 16; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word(64'h0, 4'd0, 1'b1);
    drain();

    // Random phases with different idling and digest lengths.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_length(7'd1); send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin write_length(7'd64); send_idle_pct = send_gap_pct; recv_stall_pct = 0; end
        2: begin write_length(7'd0); send_idle_pct = 0; recv_stall_pct = 71; end
        3: begin write_length(7'd127); send_idle_pct = 24; recv_stall_pct = 24; end
        4: begin write_length(7'($urandom_range(1, 64))); send_idle_pct = 0;
             recv_stall_pct = 0; end
        default: begin write_length(7'd32); send_idle_pct = 24; recv_stall_pct = 71; end
      endcase
      while (words_sent < 20 + 40 * (ph + 1)) begin
        send_message(($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 6));
        // Occasionally hold off until all digests are out.
        if ($urandom_range(7) == 0) begin
          in_valid <= 1'b0;
          while (digest_queue.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d words in %0d messages over six digest-length settings,", words_sent,
             messages_done);
    $display("with idle sender, stalled receiver and mixed pacing phases.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
